FILE: hdl/clsg_pkg.sv
// Package with the shared widths, command codes and item structures of the line step generator.
package clsg_pkg;

  localparam int POS_BITS = 20;
  localparam int CNT_W    = POS_BITS + 1;
  localparam int ACC_W    = POS_BITS + 2;
  localparam int IN_DATA_W  = ((2 * POS_BITS + 7) / 8) * 8;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    CMD_MOVE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_HOME = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] target_y;
    logic signed [POS_BITS-1:0] target_x;
    logic                       y_given;
    logic                       x_given;
    cmd_t                       command;
  } item_t;

  typedef struct packed {
    logic refused;
    logic move_finished;
    logic moving;
    logic reverse_b;
    logic pulse_b;
    logic reverse_a;
    logic pulse_a;
  } result_t;

endpackage

FILE: hdl/clsg_core.sv
// Motion state and single-pass command decode: position, motor counts and Bresenham accumulator.
module clsg_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  clsg_pkg::item_t  item,
  output clsg_pkg::result_t res
);
  import clsg_pkg::*;

  logic signed [POS_BITS-1:0] pos_x_r, pos_x_nxt;
  logic signed [POS_BITS-1:0] pos_y_r, pos_y_nxt;
  logic [CNT_W-1:0] major_total_r, major_total_nxt;
  logic [CNT_W-1:0] minor_total_r, minor_total_nxt;
  logic [CNT_W-1:0] major_left_r, major_left_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic a_is_major_r, a_is_major_nxt;
  logic dir_a_r, dir_a_nxt;
  logic dir_b_r, dir_b_nxt;
  logic busy_r, busy_nxt;

  logic signed [POS_BITS-1:0] tx, ty;
  logic signed [ACC_W-1:0]    cnt_a, cnt_b;
  logic [CNT_W-1:0]           mag_a, mag_b;
  logic                       a_major;
  logic [ACC_W-1:0]           acc_sum;
  logic [ACC_W:0]             acc_diff;
  logic                       minor_step;
  logic                       pa, pb, fin, refused;

  always_comb begin
    tx = item.x_given ? item.target_x : pos_x_r;
    ty = item.y_given ? item.target_y : pos_y_r;
    cnt_a = (tx + ty) - (pos_x_r + pos_y_r);
    cnt_b = (tx - ty) - (pos_x_r - pos_y_r);
    mag_a = cnt_a[ACC_W-1] ? CNT_W'(-cnt_a) : cnt_a[CNT_W-1:0];
    mag_b = cnt_b[ACC_W-1] ? CNT_W'(-cnt_b) : cnt_b[CNT_W-1:0];
    a_major = mag_a >= mag_b;

    acc_sum    = acc_r + ACC_W'(minor_total_r);
    acc_diff   = {1'b0, acc_sum} - (ACC_W + 1)'(major_total_r);
    minor_step = !acc_diff[ACC_W];
  end

  always_comb begin
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    major_total_nxt = major_total_r;
    minor_total_nxt = minor_total_r;
    major_left_nxt  = major_left_r;
    acc_nxt         = acc_r;
    a_is_major_nxt  = a_is_major_r;
    dir_a_nxt       = dir_a_r;
    dir_b_nxt       = dir_b_r;
    busy_nxt        = busy_r;
    pa      = 1'b0;
    pb      = 1'b0;
    fin     = 1'b0;
    refused = 1'b0;
    case (item.command)
      CMD_MOVE: begin
        if (busy_r) begin
          refused = 1'b1;
        end else begin
          pos_x_nxt       = tx;
          pos_y_nxt       = ty;
          dir_a_nxt       = cnt_a[ACC_W-1];
          dir_b_nxt       = cnt_b[ACC_W-1];
          a_is_major_nxt  = a_major;
          major_total_nxt = a_major ? mag_a : mag_b;
          minor_total_nxt = a_major ? mag_b : mag_a;
          major_left_nxt  = a_major ? mag_a : mag_b;
          acc_nxt         = '0;
          busy_nxt        = (a_major ? mag_a : mag_b) != '0;
        end
      end
      CMD_TICK: begin
        if (busy_r) begin
          acc_nxt        = minor_step ? acc_diff[ACC_W-1:0] : acc_sum;
          pa             = a_is_major_r ? 1'b1 : minor_step;
          pb             = a_is_major_r ? minor_step : 1'b1;
          major_left_nxt = major_left_r - CNT_W'(1);
          if (major_left_r == CNT_W'(1)) begin
            busy_nxt = 1'b0;
            fin      = 1'b1;
          end
        end
      end
      CMD_HOME: begin
        if (busy_r) begin
          refused = 1'b1;
        end else begin
          pos_x_nxt = '0;
          pos_y_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.pulse_a       = pa;
    res.reverse_a     = dir_a_nxt;
    res.pulse_b       = pb;
    res.reverse_b     = dir_b_nxt;
    res.moving        = busy_nxt;
    res.move_finished = fin;
    res.refused       = refused;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      major_total_r <= '0;
      minor_total_r <= '0;
      major_left_r  <= '0;
      acc_r         <= '0;
      a_is_major_r  <= 1'b1;
      dir_a_r       <= 1'b0;
      dir_b_r       <= 1'b0;
      busy_r        <= 1'b0;
    end else if (fire) begin
      pos_x_r       <= pos_x_nxt;
      pos_y_r       <= pos_y_nxt;
      major_total_r <= major_total_nxt;
      minor_total_r <= minor_total_nxt;
      major_left_r  <= major_left_nxt;
      acc_r         <= acc_nxt;
      a_is_major_r  <= a_is_major_nxt;
      dir_a_r       <= dir_a_nxt;
      dir_b_r       <= dir_b_nxt;
      busy_r        <= busy_nxt;
    end
  end

  a_busy_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> major_left_r != '0)
    else $error("busy with no major steps left");

  a_acc_below_major: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> acc_r < ACC_W'(major_total_r))
    else $error("accumulator not below major count");

  a_pulse_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.pulse_a || res.pulse_b) |-> busy_r)
    else $error("pulse issued while idle");

  a_finish_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.move_finished |=> !busy_r)
    else $error("still busy after final step");

  a_refuse_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.refused |-> busy_r)
    else $error("command refused while idle");

endmodule

FILE: hdl/corexy_line_step_generator.sv
// Top level of the CoreXY line step generator: stream ports, input register and result register.
// A command passes the input register and then the result register before out_tvalid rises.
// Throughput: one command per clock cycle while no result waits on out_tready; the tick
// path is one add, compare and subtract.
// The input and result registers let a new command enter while a result waits on out_tready.
// Reset (rst_n low, synchronous) empties both registers, zeroes position, counts and
// accumulator, clears the direction bits and idles the block with motor A as major.
module corexy_line_step_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: target_x, target_y.
  input  logic [clsg_pkg::IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: command (2 bits), x_given, y_given.
  input  logic [clsg_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: pulse_a, reverse_a, pulse_b, reverse_b, moving, move_finished,
  // refused, then one zero bit.
  output logic [clsg_pkg::OUT_DATA_W-1:0] out_tdata
);
  import clsg_pkg::*;

  item_t   item_r;
  logic    in_valid_r;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    proceed;

  assign proceed   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (proceed) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.command  <= cmd_t'(in_tuser[1:0]);
      item_r.x_given  <= in_tuser[2];
      item_r.y_given  <= in_tuser[3];
      item_r.target_x <= in_tdata[POS_BITS-1:0];
      item_r.target_y <= in_tdata[2*POS_BITS-1:POS_BITS];
    end
    if (proceed) begin
      res_r <= res;
    end
  end

  clsg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (proceed),
    .item  (item_r),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(res_r);

endmodule
